### hw/rtl/tetf_pkg.sv
// ----------------------------------------------------------------------------
// tetf_pkg
// Shared types and codes for the timed event table with event FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package tetf_pkg;

  localparam int FIELD_W = 16;

  // mode codes carried in s_tuser
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_TIMED = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] data;
    logic [FIELD_W-1:0] countdown;
  } slot_t;

  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] data;
  } event_t;

endpackage

`default_nettype wire

### hw/rtl/timed_event_table_with_fifo.sv
// ----------------------------------------------------------------------------
// timed_event_table_with_fifo
// Event FIFO plus a table of countdown timers that feed it.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_*: s_tuser holds the mode (push, pop, timed push,
//   tick), s_tdata the event id, event data and wait count. Every item gives
//   exactly one result item on m_*: accepted flag, FIFO count, front entry
//   and the number of timers moved by a tick.
//   Items are handled one at a time; s_tready is high only while idle.
//   Steps from accept to result: push and pop update the FIFO, then the
//   front entry is read and the result loads; a timed push first waits for
//   the slot index remainder unit and writes the slot; a tick walks all
//   TIMER_SLOTS slots (one slot read-modify-write per cycle, slot memory
//   read pipelined one slot ahead) before the front is read.
//   With no stall the block returns to idle, ready for the next item, as the result loads.
//   The FIFO store and the timer table are synchronous memories with a
//   registered read; the front entry is reread after each item.
//   A stalled result sits in the output register; the block stays in its
//   output state and takes no new item until the register frees up.
//   Reset clears pointers, count, control and the timer valid bits; an
//   invalid timer slot reads as all zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_event_table_with_fifo
  import tetf_pkg::*;
#(
  parameter int FIFO_DEPTH  = 64,
  parameter int TIMER_SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [15:0] event_id, [31:16] event_data, [47:32] wait_ticks
  input  wire logic [47:0] s_tdata,
  // [1:0] mode
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] accepted, [7:1] fifo_count, [8] front_valid, [24:9] front_id,
  // [40:25] front_data, [46:41] moved_count, [47] zero
  output logic [47:0]      m_tdata
);

  localparam int FW  = $clog2(FIFO_DEPTH);
  localparam int OCW = $clog2(FIFO_DEPTH + 1);
  localparam int SW  = $clog2(TIMER_SLOTS);
  localparam int CW  = $clog2(TIMER_SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_FRONT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state, state_next;

  // FIFO control
  logic [FW-1:0]  head, tail;
  logic [OCW-1:0] occ;
  logic           fifo_full;

  // memories
  event_t fifo_mem [FIFO_DEPTH];
  event_t fifo_q;
  logic   fifo_we;
  event_t fifo_wdata;

  slot_t  slot_mem [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] slot_valid;
  slot_t  slot_q;
  logic   slot_vq;
  logic   slot_we;
  logic [SW-1:0] slot_waddr;
  slot_t  slot_wdata;
  logic [SW-1:0] slot_raddr;

  // item payload
  logic [FIELD_W-1:0] ev_id, ev_data, ev_wait;
  logic               acc;
  logic [CW-1:0]      moved;

  // tick walk
  logic [CW-1:0] rd_idx;
  logic [SW-1:0] wr_idx;
  logic          pend;

  // index unit
  logic          mod_start, mod_done;
  logic [SW-1:0] mod_rem;

  logic          in_fire;
  slot_t         slot_eff;
  logic [FIELD_W-1:0] cd_dec;
  logic          fire_slot;
  logic [FIELD_W-1:0] idx_sum;

  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign fifo_full = (occ >= OCW'(FIFO_DEPTH));
  assign idx_sum   = s_tdata[15:0] + s_tdata[31:16];
  assign mod_start = in_fire && (s_tuser == MODE_TIMED);

  tetf_mod #(.DIVISOR(TIMER_SLOTS)) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .value   (idx_sum),
    .done    (mod_done),
    .rem_out (mod_rem)
  );

  // memories
  assign slot_raddr = rd_idx[SW-1:0];

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[tail] <= fifo_wdata;
    end
    fifo_q <= fifo_mem[head];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_q  <= slot_mem[slot_raddr];
    slot_vq <= slot_valid[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (slot_we) begin
      slot_valid[slot_waddr] <= 1'b1;
    end
  end

  // tick slot update
  assign slot_eff  = slot_vq ? slot_q : '0;
  assign cd_dec    = slot_eff.countdown - FIELD_W'(1);
  assign fire_slot = (cd_dec == '0) && (slot_eff.id != '0);

  always_comb begin
    state_next = state;
    fifo_we    = 1'b0;
    fifo_wdata = '{id: ev_id, data: ev_data};
    slot_we    = 1'b0;
    slot_waddr = wr_idx;
    slot_wdata = '{id: ev_id, data: ev_data, countdown: ev_wait};
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (s_tuser)
            MODE_PUSH: begin
              fifo_we    = !fifo_full;
              fifo_wdata = '{id: s_tdata[15:0], data: s_tdata[31:16]};
              state_next = S_FRONT;
            end
            MODE_POP:   state_next = S_FRONT;
            MODE_TIMED: state_next = S_MOD;
            default:    state_next = S_TICK;
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          slot_we    = 1'b1;
          slot_waddr = mod_rem;
          state_next = S_FRONT;
        end
      end
      S_TICK: begin
        if (pend) begin
          slot_we = 1'b1;
          if (fire_slot && !fifo_full) begin
            fifo_we    = 1'b1;
            fifo_wdata = '{id: slot_eff.id, data: slot_eff.data};
            slot_wdata = '0;
          end else if (fire_slot) begin
            slot_wdata = '{id: slot_eff.id, data: slot_eff.data, countdown: FIELD_W'(1)};
          end else begin
            slot_wdata = '{id: slot_eff.id, data: slot_eff.data, countdown: cd_dec};
          end
          if (rd_idx == CW'(TIMER_SLOTS)) begin
            state_next = S_FRONT;
          end
        end
      end
      S_FRONT: state_next = S_OUT;
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      occ   <= '0;
    end else begin
      state <= state_next;
      if (fifo_we) begin
        tail <= (tail == FW'(FIFO_DEPTH - 1)) ? '0 : tail + FW'(1);
      end
      if (in_fire && s_tuser == MODE_POP && occ != '0) begin
        head <= (head == FW'(FIFO_DEPTH - 1)) ? '0 : head + FW'(1);
        occ  <= occ - OCW'(1);
      end else if (fifo_we) begin
        occ <= occ + OCW'(1);
      end
    end
  end

  // payload and tick walk registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_id   <= s_tdata[15:0];
      ev_data <= s_tdata[31:16];
      ev_wait <= s_tdata[47:32];
      moved   <= '0;
      rd_idx  <= '0;
      pend    <= 1'b0;
      case (s_tuser)
        MODE_PUSH: acc <= !fifo_full;
        MODE_POP:  acc <= (occ != '0);
        default:   acc <= 1'b1;
      endcase
    end else if (state == S_TICK) begin
      if (rd_idx < CW'(TIMER_SLOTS)) begin
        rd_idx <= rd_idx + CW'(1);
        wr_idx <= rd_idx[SW-1:0];
        pend   <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
      if (pend && fire_slot && !fifo_full) begin
        moved <= moved + CW'(1);
      end
    end
  end

  // result register
  logic [OCW+7:0] occ_w;
  logic [CW+7:0]  moved_w;
  logic [6:0]     cnt_sat;
  logic [5:0]     moved_sat;
  event_t         front;

  assign occ_w     = (OCW+8)'(occ);
  assign moved_w   = (CW+8)'(moved);
  assign cnt_sat   = (occ_w > (OCW+8)'(127)) ? 7'd127 : occ_w[6:0];
  assign moved_sat = (moved_w > (CW+8)'(63)) ? 6'd63 : moved_w[5:0];
  assign front     = (occ != '0) ? fifo_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, moved_sat, front.data, front.id, (occ != '0), cnt_sat, acc};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tetf_mod.sv
// ----------------------------------------------------------------------------
// tetf_mod
// Remainder of a 16-bit value by a constant for the timer slot index, by
// reciprocal multiplication and one correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module tetf_mod
  import tetf_pkg::*;
#(
  parameter int DIVISOR = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [FIELD_W-1:0]         value,
  output logic                            done,
  output logic [$clog2(DIVISOR)-1:0]      rem_out
);

  localparam int RW    = $clog2(DIVISOR);
  localparam int RECIP = (1 << FIELD_W) / DIVISOR;

  logic [FIELD_W-1:0]   val;
  logic [2*FIELD_W-1:0] prod;
  logic [FIELD_W-1:0]   quo;
  logic [FIELD_W-1:0]   part;
  logic [FIELD_W-1:0]   rem;
  logic [FIELD_W-1:0]   rem_adj;
  logic                 run;

  // quotient estimate is low by at most one, so one compare and subtract fixes it
  assign quo     = prod[2*FIELD_W-1:FIELD_W];
  assign part    = FIELD_W'(32'(quo) * 32'(DIVISOR));
  assign rem_adj = (rem >= FIELD_W'(DIVISOR)) ? rem - FIELD_W'(DIVISOR) : rem;
  assign rem_out = rem_adj[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      run  <= start;
      done <= run;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      prod <= (2*FIELD_W)'(value) * (2*FIELD_W)'(RECIP);
    end
    if (run) begin
      rem <= val - part;
    end
  end

endmodule

`default_nettype wire
